// ===== hdl/prbd_pkg.sv =====
// Shared constants of the per-rule burst detector: field widths, register indexes, reset values.
package prbd_pkg;

  localparam int RULE_W_IN   = 4;
  localparam int TIME_W      = 32;
  localparam int WINDOW_W    = 16;
  localparam int THRESH_W    = 6;
  localparam int RECENT_W    = 6;
  localparam int RECENT_MAX  = 63;

  // s_tdata: rule_number, hit_time, padded to whole bytes
  localparam int S_FIELDS_W  = RULE_W_IN + TIME_W;
  localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
  // m_tdata: recent_hits, burst_start, burst_on
  localparam int M_DATA_W    = 8;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW    = 4'd0,
    REG_THRESHOLD = 4'd1
  } cfg_reg_t;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd10;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 6'd5;

endpackage

// ===== hdl/prbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/per_rule_burst_detector.sv =====
// Per-rule burst detector: ring of hit times per rule, windowed count, burst flag per rule.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: rule_number, hit_time
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: recent_hits, burst_start, burst_on
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// An in-range hit raises m_tvalid after a metadata step (ST_META), a scan (ST_SCAN)
// that runs one compare of the shared 32-bit subtract per stored time, paced by the
// single read port of the hit-time RAM, a drain of the last read, and the result step
// (ST_DONE). s_tready returns as the result is issued, so a new hit is taken only once
// the result of the last one has been issued.
// A rule outside RULE_COUNT skips the scan; ST_DONE gives it an all-zero result.
// Reset (rst, synchronous) clears per-rule valid bits, so no clearing pass is needed.
// A stalled result holds in the output register; the next hit waits in ST_DONE.
module per_rule_burst_detector #(
  parameter int RULE_COUNT     = 16,
  parameter int SLOTS_PER_RULE = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [prbd_pkg::S_DATA_W-1:0]   s_tdata,   // [3:0] rule_number, [35:4] hit_time
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [prbd_pkg::M_DATA_W-1:0]   m_tdata,   // [5:0] recent_hits, [6] burst_start,
                                                     // [7] burst_on
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [prbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import prbd_pkg::*;

  localparam int RULE_W  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int SLOT_W  = $clog2(SLOTS_PER_RULE);
  localparam int CNT_W   = $clog2(SLOTS_PER_RULE + 1);
  localparam int CMP_W   = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
  localparam int ROWS    = 1 << RULE_W;
  localparam int TADDR_W = RULE_W + SLOT_W;

  typedef struct packed {
    logic [CNT_W-1:0]  fill;
    logic [SLOT_W-1:0] slot;
    logic              flag;
  } meta_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t             state;
  logic [RULE_W-1:0]  rule_q;
  logic [TIME_W-1:0]  now_q;
  logic               in_range;
  logic [CNT_W-1:0]   fill_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               flag_q;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   hit_count;
  logic               rd_pend;
  logic [ROWS-1:0]    vld;
  logic [WINDOW_W-1:0] window;
  logic [THRESH_W-1:0] threshold;

  logic [RULE_W_IN-1:0] s_rule;
  logic [TIME_W-1:0]    s_time;
  logic                 s_in_range;
  meta_t                meta_rdata;
  meta_t                meta_cur;
  meta_t                meta_wdata;
  logic                 meta_we;
  logic [TIME_W-1:0]    time_rdata;
  logic [TIME_W-1:0]    age;
  logic                 is_recent;
  logic                 reach;
  logic                 flag_new;
  logic                 start;
  logic                 out_free;
  logic [RECENT_W-1:0]  recent_sat;

  assign s_rule     = s_tdata[RULE_W_IN-1:0];
  assign s_time     = s_tdata[RULE_W_IN +: TIME_W];
  assign s_in_range = 32'(s_rule) < RULE_COUNT;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // a rule never written reads as empty
  assign meta_cur = vld[rule_q] ? meta_rdata : '0;

  // shared compare unit: signed distance, negative counts as recent
  assign age       = now_q - time_rdata;
  assign is_recent = age[TIME_W-1] || (age <= TIME_W'(window));

  assign reach    = CMP_W'(hit_count) >= CMP_W'(threshold);
  assign flag_new = reach;
  assign start    = reach && !flag_q;

  assign recent_sat = (CMP_W'(hit_count) > CMP_W'(RECENT_MAX)) ? RECENT_W'(RECENT_MAX)
                                                                : RECENT_W'(hit_count);

  assign meta_we    = (state == ST_DONE) && out_free && in_range;
  assign meta_wdata = '{fill: fill_q, slot: slot_q, flag: flag_new};

  prbd_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (ROWS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (rule_q),
    .wdata (meta_wdata),
    .raddr (RULE_W'(s_rule)),
    .rdata (meta_rdata)
  );

  prbd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (ROWS << SLOT_W)
  ) u_time_ram (
    .clk   (clk),
    .we    (state == ST_META),
    .waddr (TADDR_W'({rule_q, meta_cur.slot})),
    .wdata (now_q),
    .raddr (TADDR_W'({rule_q, idx[SLOT_W-1:0]})),
    .rdata (time_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      rd_pend   <= 1'b0;
      vld       <= '0;
      window    <= WINDOW_RESET;
      threshold <= THRESHOLD_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW:    window    <= cfg_data[WINDOW_W-1:0];
          REG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
          default:       ;
        endcase
      end

      // drop a taken result unless a new one is being issued
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rule_q    <= RULE_W'(s_rule);
            now_q     <= s_time;
            in_range  <= s_in_range;
            idx       <= '0;
            hit_count <= '0;
            state     <= s_in_range ? ST_META : ST_DONE;
          end
        end
        ST_META: begin
          // store the hit, advance the ring, saturate the fill count
          fill_q <= (32'(meta_cur.fill) < SLOTS_PER_RULE) ? meta_cur.fill + 1'b1
                                                          : meta_cur.fill;
          slot_q <= (32'(meta_cur.slot) == SLOTS_PER_RULE - 1) ? '0
                                                               : meta_cur.slot + 1'b1;
          flag_q <= meta_cur.flag;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_pend <= (idx < fill_q);
          if (idx < fill_q) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend && is_recent) begin
            hit_count <= hit_count + 1'b1;
          end
          if ((idx == fill_q) && !rd_pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (in_range) begin
              m_tdata   <= {flag_new, start, recent_sat};
              vld[rule_q] <= 1'b1;
            end else begin
              m_tdata <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start_has_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[RECENT_W] || m_tdata[RECENT_W+1]))
    else $error("burst_start without burst_on");

  a_count_le_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (hit_count <= idx))
    else $error("recent count ran ahead of issued reads");

  a_idx_le_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= fill_q))
    else $error("scan index passed the fill count");

  a_pend_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == ST_SCAN))
    else $error("read pending outside the scan");

endmodule
